@@ design/php_pkg.sv @@
// Shared types, constants and helpers of the PES header parser.
package php_pkg;

  // Fixed field widths of the stream payloads.
  localparam int BYTE_W      = 8;
  localparam int PID_W       = 13;
  localparam int PTS_W       = 33;
  localparam int PTS_RAW_W   = 40;
  localparam int CNT_W       = 20;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_PAD_W   = 3;

  // Default sizes of the top level.
  localparam int COUNT_BITS_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Byte offsets inside the PES header.
  localparam int POS_START_LAST = 2;
  localparam int POS_STREAM_ID  = 3;
  localparam int POS_MIN_LAST   = 5;
  localparam int POS_HELD_HI    = 6;
  localparam int POS_FLAGS      = 7;
  localparam int POS_HDR_LEN    = 8;
  localparam int POS_PTS_FIRST  = 9;
  localparam int POS_PTS_LAST   = 13;

  // Start code bytes and the PTS flag.
  localparam logic [BYTE_W-1:0] START_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] START_ONE  = 8'h01;
  localparam int                FLAG_PTS_BIT = 7;

  // Summary status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_SHORT      = 2'd1,
    ST_BAD_START  = 2'd2,
    ST_NO_PAYLOAD = 2'd3
  } status_t;

  // Result kinds, carried on tuser.
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  // One queued command: up to two payload bytes, then an optional summary.
  typedef struct packed {
    logic [1:0]        nbytes;
    logic [BYTE_W-1:0] byte_a;
    logic [BYTE_W-1:0] byte_b;
    logic              summary;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] sid;
    logic [PTS_W-1:0]  pts;
    logic              pts_valid;
    logic [CNT_W-1:0]  cnt;
    status_t           status;
  } cmd_t;

  // Assemble the 33-bit timestamp from the five PTS bytes, marker bits dropped.
  function automatic logic [PTS_W-1:0] build_pts(input logic [PTS_RAW_W-1:0] raw);
    build_pts = {raw[35:33], raw[31:24], raw[23:17], raw[15:8], raw[7:1]};
  endfunction

endpackage

@@ design/pes_header_parser.sv @@
// Top level of the PES header parser: front end, command queue and result sequencer.
//
//  channel | dir | tdata (low bit up)                                    | tuser | tlast
//  s_*     | in  | data_byte[7:0], stream_pid[20:8], zero pad            |  -    | last_byte
//  m_*     | out | payload_byte, pid_out, sid, pts, pts_valid,           | kind  | last_result
//          |     | payload_count, status, zero pad                       |       |
//
// One input item is taken per cycle while the command queue has room.
// Each input yields zero to three output items, given one per cycle while m_tready is high;
// the held-byte flush at offset 7 gives three.
// The queue (QUEUE_DEPTH commands) lets the input keep flowing while the output stalls.
// Reset is synchronous and clears the packet state and the queue; no clearing pass.
module pes_header_parser #(
  parameter int COUNT_BITS  = php_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = php_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [php_pkg::IN_TDATA_W-1:0]   s_tdata,   // data_byte, stream_pid
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [php_pkg::OUT_TDATA_W-1:0]  m_tdata,   // payload_byte, pid_out, sid,
                                                      // pts, pts_valid, payload_count, status
  output logic                             m_tuser,   // kind
  output logic                             m_tlast
);

  logic          push_valid;
  logic          push_ready;
  php_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  php_pkg::cmd_t pop_cmd;

  // Header capture and command build.
  php_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue.
  php_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Result sequencing.
  php_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ design/php_front.sv @@
// Front end: tracks the byte position, captures header fields, builds commands.
module php_front #(
  parameter int COUNT_BITS = php_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [php_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               s_tlast,
  output logic                               push_valid,
  input  logic                               push_ready,
  output php_pkg::cmd_t                      push_cmd
);

  localparam logic [COUNT_BITS-1:0] POS_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]             byte_position;
  logic                              start_code_bad;
  logic [php_pkg::BYTE_W-1:0]        captured_sid;
  logic [php_pkg::BYTE_W-1:0]        flags_byte;
  logic [php_pkg::BYTE_W-1:0]        header_len_byte;
  logic [php_pkg::PTS_RAW_W-1:0]     pts_bytes;
  logic [php_pkg::BYTE_W-1:0]        held_hi;
  logic [COUNT_BITS-1:0]             payload_counter;

  logic [php_pkg::BYTE_W-1:0]        b;
  logic [php_pkg::PID_W-1:0]         pid;
  logic                              accept;
  logic                              bad_next;
  logic                              pay_now;
  logic                              in_pts;
  logic [php_pkg::PTS_RAW_W-1:0]     pts_bytes_next;
  logic [COUNT_BITS-1:0]             pos_off;
  logic [1:0]                        nbytes;
  logic [COUNT_BITS:0]               cnt_sum;
  logic [COUNT_BITS-1:0]             counter_next;
  logic [COUNT_BITS+php_pkg::CNT_W-1:0] cnt_ext;
  logic                              is_short;
  logic                              held_ok;
  php_pkg::cmd_t                     cmd;

  assign b      = s_tdata[php_pkg::BYTE_W-1:0];
  assign pid    = s_tdata[php_pkg::BYTE_W +: php_pkg::PID_W];
  assign accept = s_tvalid && s_tready;

  assign s_tready = push_ready;

  // Classify the byte and work out the command it causes.
  always_comb begin
    bad_next = start_code_bad;
    if (byte_position < COUNT_BITS'(php_pkg::POS_START_LAST)) begin
      if (b != php_pkg::START_ZERO) bad_next = 1'b1;
    end else if (byte_position == COUNT_BITS'(php_pkg::POS_START_LAST)) begin
      if (b != php_pkg::START_ONE) bad_next = 1'b1;
    end

    in_pts = (byte_position >= COUNT_BITS'(php_pkg::POS_PTS_FIRST)) &&
             (byte_position <= COUNT_BITS'(php_pkg::POS_PTS_LAST));
    pts_bytes_next = in_pts ? {pts_bytes[php_pkg::PTS_RAW_W-php_pkg::BYTE_W-1:0], b}
                            : pts_bytes;

    pos_off = byte_position - COUNT_BITS'(php_pkg::POS_PTS_FIRST);
    pay_now = (byte_position >= COUNT_BITS'(php_pkg::POS_PTS_FIRST)) && !bad_next &&
              (pos_off >= COUNT_BITS'(header_len_byte));

    is_short = byte_position < COUNT_BITS'(php_pkg::POS_MIN_LAST);
    held_ok  = s_tlast && !is_short && !bad_next;

    cmd           = '0;
    cmd.pid       = pid;
    cmd.summary   = s_tlast;
    cmd.status    = php_pkg::ST_OK;
    nbytes        = {1'b0, pay_now};
    cmd.byte_a    = b;
    cmd.byte_b    = b;
    // Held header bytes are flushed as payload when the packet ends early.
    if (held_ok && byte_position == COUNT_BITS'(php_pkg::POS_HELD_HI)) begin
      nbytes = 2'd1;
    end else if (held_ok && byte_position == COUNT_BITS'(php_pkg::POS_FLAGS)) begin
      nbytes     = 2'd2;
      cmd.byte_a = held_hi;
    end
    cmd.nbytes = nbytes;

    // Saturating payload count after this byte's emits.
    cnt_sum      = {1'b0, payload_counter} + (COUNT_BITS+1)'(nbytes);
    counter_next = cnt_sum[COUNT_BITS] ? POS_MAX : cnt_sum[COUNT_BITS-1:0];
    cnt_ext      = {{php_pkg::CNT_W{1'b0}}, counter_next};

    if (is_short) begin
      cmd.status = php_pkg::ST_SHORT;
    end else if (bad_next) begin
      cmd.status = php_pkg::ST_BAD_START;
    end else if (s_tlast) begin
      cmd.sid = captured_sid;
      if (flags_byte[php_pkg::FLAG_PTS_BIT] &&
          byte_position >= COUNT_BITS'(php_pkg::POS_PTS_LAST)) begin
        cmd.pts_valid = 1'b1;
        cmd.pts       = php_pkg::build_pts(pts_bytes_next);
      end
      cmd.cnt    = cnt_ext[php_pkg::CNT_W-1:0];
      cmd.status = (counter_next == '0) ? php_pkg::ST_NO_PAYLOAD : php_pkg::ST_OK;
    end
  end

  assign push_valid = accept && (s_tlast || nbytes != 2'd0);
  assign push_cmd   = cmd;

  // Packet state: captured on each accepted item, cleared after the last one.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      byte_position      <= '0;
      start_code_bad     <= 1'b0;
      captured_sid       <= '0;
      flags_byte         <= '0;
      header_len_byte    <= '0;
      pts_bytes          <= '0;
      held_hi            <= '0;
      payload_counter    <= '0;
    end else if (accept) begin
      start_code_bad  <= bad_next;
      pts_bytes       <= pts_bytes_next;
      payload_counter <= counter_next;
      if (byte_position != POS_MAX) byte_position <= byte_position + 1'b1;
      if (byte_position == COUNT_BITS'(php_pkg::POS_STREAM_ID)) captured_sid <= b;
      if (byte_position == COUNT_BITS'(php_pkg::POS_HELD_HI)) held_hi <= b;
      if (byte_position == COUNT_BITS'(php_pkg::POS_FLAGS)) flags_byte <= b;
      if (byte_position == COUNT_BITS'(php_pkg::POS_HDR_LEN)) header_len_byte <= b;
    end
  end

  // A queued command always yields at least one result.
  a_cmd_nonempty: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_cmd.summary || push_cmd.nbytes != 2'd0))
    else $error("front pushed a command with no results");

  // The end of a packet returns the position to the start.
  a_pos_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (byte_position == '0 && payload_counter == '0))
    else $error("packet state not cleared after the last byte");

  // Payload bytes never come out of a packet with a bad start code.
  a_bad_no_payload: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_cmd.status == php_pkg::ST_BAD_START) |-> push_cmd.nbytes == 2'd0)
    else $error("payload emitted after a bad start code");

endmodule

@@ design/php_queue.sv @@
// Short command queue between the front end and the result sequencer.
module php_queue #(
  parameter int DEPTH = php_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  php_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output php_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  php_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

@@ design/php_back.sv @@
// Back end: expands each queued command into its payload and summary items.
module php_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  php_pkg::cmd_t                      pop_cmd,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [php_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast
);

  logic [1:0]                 idx;
  logic [1:0]                 total;
  logic                       is_payload;
  logic                       is_final;
  logic                       out_acc;
  logic [php_pkg::BYTE_W-1:0] pbyte;
  php_pkg::cmd_t              fields;

  assign total      = pop_cmd.nbytes + {1'b0, pop_cmd.summary};
  assign is_payload = idx < pop_cmd.nbytes;
  assign is_final   = (idx == total - 2'd1);
  assign out_acc    = m_tvalid && m_tready;

  // Pick the fields of the current item of the head command.
  always_comb begin
    fields = '0;
    pbyte  = '0;
    fields.pid = pop_cmd.pid;
    if (is_payload) begin
      pbyte = (idx == 2'd0) ? pop_cmd.byte_a : pop_cmd.byte_b;
    end else begin
      fields = pop_cmd;
    end
  end

  assign m_tvalid  = pop_valid;
  assign m_tlast   = is_final;
  assign m_tuser   = is_payload ? php_pkg::KIND_PAYLOAD : php_pkg::KIND_SUMMARY;
  assign m_tdata   = {{php_pkg::OUT_PAD_W{1'b0}}, fields.status, fields.cnt,
                      fields.pts_valid, fields.pts, fields.sid, fields.pid, pbyte};
  assign pop_ready = m_tready && is_final;

  // Item index within the head command.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_acc) begin
      idx <= is_final ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> idx < total)
    else $error("item index beyond the command's results");

endmodule

@@ tb/sv/pes_header_parser_tb.sv @@
// Self-checking testbench for the PES header parser: directed packets, then random traffic.
module pes_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import php_pkg::*;

  // Counter width of the block under test.
  localparam int          TB_COUNT_BITS  = COUNT_BITS_DEF;
  localparam int unsigned POS_MAX        = (1 << TB_COUNT_BITS) - 1;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          MAX_REPORTS    = 40;
  localparam int          PHASE_ITEMS    = 56;

  typedef logic [BYTE_W-1:0] pes_byte_q_t[$];

  // One result word as it appears on m_tdata, last field in the lowest bits.
  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    status_t              status;
    logic [CNT_W-1:0]     count;
    logic                 pts_valid;
    logic [PTS_W-1:0]     pts;
    logic [BYTE_W-1:0]    sid;
    logic [PID_W-1:0]     pid;
    logic [BYTE_W-1:0]    data;
  } out_word_t;

  // One expected result of the parser.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] sid;
    logic [PTS_W-1:0]  pts;
    logic              pts_valid;
    logic [CNT_W-1:0]  count;
    status_t           status;
    logic              last;
  } pes_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // data_byte, stream_pid
  logic                   s_tlast = 1'b0; // last_byte
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // payload_byte, pid_out, sid, pts,
                                          // pts_valid, payload_count, status
  logic                   m_tuser;        // kind
  logic                   m_tlast;        // last_result

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned mismatch_count = 0;

  pes_result_t pending_pes_results[$];

  // Parser state of the predictor.
  int unsigned             next_pos    = 0;
  logic                    start_bad   = 1'b0;
  logic [BYTE_W-1:0]       cap_sid     = '0;
  logic [BYTE_W-1:0]       cap_flags   = '0;
  logic [BYTE_W-1:0]       cap_hdr_len = '0;
  logic [PTS_RAW_W-1:0]    pts_shift   = '0;
  logic [2*BYTE_W-1:0]     held_pair   = '0;
  int unsigned             emitted     = 0;

  pes_header_parser #(
    .COUNT_BITS(TB_COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Queue one payload byte result and advance the saturating payload count.
  function automatic void add_payload(input logic [BYTE_W-1:0] b, input logic [PID_W-1:0] pid);
    pes_result_t r;
    r = '0;
    r.kind = KIND_PAYLOAD;
    r.data = b;
    r.pid = pid;
    r.status = ST_OK;
    pending_pes_results.push_back(r);
    if (emitted < POS_MAX) emitted++;
  endfunction

  // Work out the results that one accepted packet byte causes.
  function automatic void parse_pes_byte(input logic [BYTE_W-1:0] b, input logic last,
                                         input logic [PID_W-1:0] pid);
    int unsigned pos;
    int          n;
    pes_result_t s;
    pos = next_pos;
    n = 0;
    // Capture the fixed header fields by position.
    if (pos <= POS_START_LAST && b != ((pos == POS_START_LAST) ? START_ONE : START_ZERO))
      start_bad = 1'b1;
    if (pos == POS_STREAM_ID) cap_sid = b;
    if (pos == POS_HELD_HI) held_pair[15:8] = b;
    if (pos == POS_FLAGS) begin
      held_pair[7:0] = b;
      cap_flags = b;
    end
    if (pos == POS_HDR_LEN) cap_hdr_len = b;
    if (pos >= POS_PTS_FIRST && pos <= POS_PTS_LAST) pts_shift = {pts_shift[31:0], b};
    // Payload starts once the optional header bytes are over.
    if (pos >= POS_PTS_FIRST && !start_bad && pos >= POS_PTS_FIRST + cap_hdr_len) begin
      add_payload(b, pid);
      n++;
    end
    if (last) begin
      s = '0;
      s.kind = KIND_SUMMARY;
      s.pid = pid;
      s.last = 1'b1;
      if (pos < POS_MIN_LAST) begin
        s.status = ST_SHORT;
      end else if (start_bad) begin
        s.status = ST_BAD_START;
      end else begin
        // A packet that stops inside the held bytes flushes them as payload.
        if (pos == POS_HELD_HI || pos == POS_FLAGS) add_payload(held_pair[15:8], pid);
        if (pos == POS_FLAGS) add_payload(held_pair[7:0], pid);
        s.sid = cap_sid;
        if (cap_flags[FLAG_PTS_BIT] && pos >= POS_PTS_LAST) begin
          s.pts_valid = 1'b1;
          // Three, fifteen and fifteen timestamp bits, marker bits dropped.
          s.pts = {pts_shift[35:33], pts_shift[31:24], pts_shift[23:17],
                   pts_shift[15:8], pts_shift[7:1]};
        end
        s.count = emitted[CNT_W-1:0];
        s.status = (emitted == 0) ? ST_NO_PAYLOAD : ST_OK;
      end
      pending_pes_results.push_back(s);
      next_pos = 0;
      start_bad = 1'b0;
      cap_sid = '0;
      cap_flags = '0;
      cap_hdr_len = '0;
      pts_shift = '0;
      held_pair = '0;
      emitted = 0;
    end else begin
      if (pos < POS_MAX) next_pos = pos + 1;
      if (n > 0) pending_pes_results[pending_pes_results.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("%0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_word_t   got;
    pes_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_pes_results.size() == 0) begin
        report_mismatch("result item arrived with nothing pending");
      end else begin
        want = pending_pes_results.pop_front();
        check_field("kind", m_tuser, want.kind);
        check_field("payload_byte", got.data, want.data);
        check_field("pid_out", got.pid, want.pid);
        check_field("sid", got.sid, want.sid);
        check_field("pts", got.pts, want.pts);
        check_field("pts_valid", got.pts_valid, want.pts_valid);
        check_field("payload_count", got.count, want.count);
        check_field("status", got.status, want.status);
        check_field("last_result", m_tlast, want.last);
      end
    end
  end

  // Send one packet byte, idling at random first, and predict once it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                           input logic [PID_W-1:0] pid);
    bit paused;
    paused = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!paused) s_tvalid <= 1'b0;
      paused = 1'b1;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - PID_W - BYTE_W){1'b0}}, pid, b};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_pes_byte(b, last, pid);
    bytes_sent++;
  endtask

  // Send a whole packet; the PID may hop on single bytes.
  task automatic send_packet(input pes_byte_q_t pkt, input logic [PID_W-1:0] pid,
                             input int unsigned pid_hop_pct);
    logic [PID_W-1:0] p;
    for (int i = 0; i < pkt.size(); i++) begin
      p = ($urandom_range(99) < pid_hop_pct) ? PID_W'($urandom) : pid;
      send_byte(pkt[i], i == pkt.size() - 1, p);
    end
  endtask

  // Pause the sender until every expected result is out, then let the block settle.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_pes_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Nine-byte PES header: start code, stream id, length, marker byte, flags, header length.
  function automatic pes_byte_q_t pes_header(input logic [BYTE_W-1:0] sid,
                                             input logic [BYTE_W-1:0] flags,
                                             input logic [BYTE_W-1:0] hdr_len);
    pes_header = {START_ZERO, START_ZERO, START_ONE, sid, BYTE_W'($urandom),
                  BYTE_W'($urandom), BYTE_W'($urandom), flags, hdr_len};
  endfunction

  // Packets that end before the header is complete.
  task automatic test_short_packets();
    pes_byte_q_t pkt;
    int          lens[4] = '{1, 3, 5, 6};
    pkt = pes_header(8'hE0, 8'h80, 8'h05);
    foreach (lens[i]) send_packet(pkt[0:lens[i]-1], (i % 2) ? '1 : '0, 0);
    wait_for_results();
  endtask

  // A wrong byte in each start code position suppresses the payload.
  task automatic test_bad_start_code();
    pes_byte_q_t pkt;
    for (int pos = 0; pos <= POS_START_LAST; pos++) begin
      pkt = pes_header(8'hC0, 8'h00, 8'h00);
      pkt[pos] = pkt[pos] ^ 8'h01;
      pkt.push_back(8'h55);
      send_packet(pkt, '1, 0);
    end
    wait_for_results();
  endtask

  // Ends at byte 6, at byte 7 and at the header length byte.
  task automatic test_held_bytes();
    pes_byte_q_t pkt;
    pkt = pes_header(8'h00, 8'h00, 8'h00);
    pkt[POS_HELD_HI] = 8'hFF;
    send_packet(pkt[0:POS_HELD_HI], 13'h0ABC, 0);
    send_packet(pkt[0:POS_FLAGS], 13'h1543, 0);
    send_packet(pkt, 13'h0001, 0);
    wait_for_results();
  endtask

  // PTS with and without payload, overlapping payload, cut short, PID hops.
  task automatic test_pts_capture();
    pes_byte_q_t pkt;
    pkt = pes_header(8'hBD, 8'h80, 8'h05);
    repeat (5) pkt.push_back(8'hFF);
    send_packet(pkt, 13'h1000, 0);
    pkt = pes_header(8'hFF, 8'hC0, 8'h00);
    repeat (5) pkt.push_back(8'h00);
    pkt.push_back(8'hA5);
    pkt.push_back(8'h5A);
    send_packet(pkt, 13'h0FFF, 50);
    pkt = pes_header(8'hE1, 8'hFF, 8'h00);
    repeat (4) pkt.push_back(8'h21);
    send_packet(pkt, 13'h0100, 0);
    wait_for_results();
  endtask

  // Largest header length ends inside the header with no payload; a 32-byte
  // header length with two payload bytes after it checks where payload starts.
  task automatic test_max_header_length();
    pes_byte_q_t pkt;
    pkt = pes_header(8'hE0, 8'h80, 8'hFF);
    repeat (11) pkt.push_back(BYTE_W'($urandom));
    send_packet(pkt, 13'h0777, 0);
    pkt = pes_header(8'hE2, 8'h80, 8'h20);
    repeat (32 + 2) pkt.push_back(BYTE_W'($urandom));
    send_packet(pkt, 13'h0778, 0);
    wait_for_results();
  endtask

  // Mostly well-formed packets with random content, some cut short, some noise.
  task automatic send_random_packet();
    pes_byte_q_t pkt;
    int          pick;
    int          n;
    int          k;
    logic [7:0]  flags;
    pick = $urandom_range(99);
    flags = ($urandom_range(9) < 7) ? (BYTE_W'($urandom) | 8'h80) : BYTE_W'($urandom);
    if (pick < 75) begin
      n = ($urandom_range(29) == 0) ? $urandom_range(48) : $urandom_range(8);
      pkt = pes_header(BYTE_W'($urandom), flags, BYTE_W'(n));
      repeat (n + $urandom_range(12)) pkt.push_back(BYTE_W'($urandom));
    end else begin
      n = (pick < 90) ? $urandom_range(1, 14) : $urandom_range(1, 20);
      pkt = pes_header(BYTE_W'($urandom), flags, BYTE_W'($urandom_range(8)));
      while (pkt.size() < n) pkt.push_back(BYTE_W'($urandom));
      while (pkt.size() > n) void'(pkt.pop_back());
      // Noise: either all random bytes or one flipped start code bit.
      if (pick >= 90) begin
        if ($urandom_range(1)) begin
          foreach (pkt[i]) pkt[i] = BYTE_W'($urandom);
        end else begin
          k = $urandom_range(0, (n < 3) ? n - 1 : POS_START_LAST);
          pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(7));
        end
      end
    end
    send_packet(pkt, PID_W'($urandom), 4);
  endtask

  // One traffic phase with the given idle and stall rates.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = bytes_sent + PHASE_ITEMS;
    while (bytes_sent < target) begin
      send_random_packet();
      if ($urandom_range(9) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_short_packets();
    test_bad_start_code();
    test_held_bytes();
    test_pts_capture();
    test_max_header_length();
    test_random_traffic(0, 0);
    test_random_traffic(70, 0);
    test_random_traffic(0, 70);
    test_random_traffic(23, 23);
    wait_for_results();
    if (mismatch_count == 0 && pending_pes_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
design/php_pkg.sv
design/php_front.sv
design/php_queue.sv
design/php_back.sv
design/pes_header_parser.sv
tb/sv/pes_header_parser_tb.sv
